@@ design/i2cms_pkg.sv @@
package i2cms_pkg;

    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DELAY_W = 18;

    localparam logic [ADDR_W-1:0] REG_TICKS_PER_UNIT    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_ACK_TIMEOUT_LIMIT = 3'd4;

    localparam logic [15:0] TICKS_PER_UNIT_RST    = 16'd1;
    localparam logic [15:0] ACK_TIMEOUT_LIMIT_RST = 16'd1000;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;
    localparam logic [2:0] KIND_WAIT  = 3'd5;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_WR_SETUP,
        PH_WR_HIGH,
        PH_WR_LOW,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_RD_HOLD,
        PH_AK_LOW,
        PH_AK_HIGH,
        PH_WA_REL,
        PH_WA_HIGH,
        PH_WA_POLL
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_sample;
    } cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_failed;
    } res_t;

endpackage

@@ design/i2cms_cmd_if.sv @@
interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sample;

    modport source (output valid, kind, write_byte, send_ack, sda_sample, input ready);
    modport sink (input valid, kind, write_byte, send_ack, sda_sample, output ready);
endinterface

@@ design/i2cms_res_if.sv @@
interface i2cms_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_failed;

    modport source (
        output valid, scl_level, sda_level, sda_drive, busy_res, done_res, read_byte,
               ack_failed,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, sda_drive, busy_res, done_res, read_byte,
               ack_failed,
        output ready
    );
endinterface

@@ design/i2c_master_bit_sequencer.sv @@
// The pin sequencer steps on each accepted tick, and its result enters the output
// buffer as the tick is accepted; one tick per cycle while the buffer has room.
// A two-entry output buffer keeps ticks flowing while one result waits downstream.
// Reset (rst_n low, asynchronous): sequencer idle, SCL and SDA driven high,
// ticks_per_unit 1, ack_timeout_limit 1000, output buffer empty.
module i2c_master_bit_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cms_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    i2cms_cmd_if.sink                      cmd,
    i2cms_res_if.source                    res
);

    logic [15:0]     tpu_reg;
    logic [15:0]     tmo_lim_reg;
    logic            cfg_wr;
    logic            take;
    logic            pop;
    i2cms_pkg::cmd_t cmd_in;
    i2cms_pkg::res_t res_new;
    i2cms_pkg::res_t slot0_reg;
    i2cms_pkg::res_t slot1_reg;
    logic [1:0]      cnt_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg     <= i2cms_pkg::TICKS_PER_UNIT_RST;
            tmo_lim_reg <= i2cms_pkg::ACK_TIMEOUT_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == i2cms_pkg::REG_ACK_TIMEOUT_LIMIT[2])
                tmo_lim_reg <= pwdata[15:0];
            else
                tpu_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            i2cms_pkg::REG_TICKS_PER_UNIT:    prdata = {16'd0, tpu_reg};
            i2cms_pkg::REG_ACK_TIMEOUT_LIMIT: prdata = {16'd0, tmo_lim_reg};
            default:                          prdata = 32'd0;
        endcase
    end

    assign cmd_in.kind       = cmd.kind;
    assign cmd_in.write_byte = cmd.write_byte;
    assign cmd_in.send_ack   = cmd.send_ack;
    assign cmd_in.sda_sample = cmd.sda_sample;

    assign cmd.ready = (cnt_reg != 2'd2);
    assign take      = cmd.valid && cmd.ready;
    assign pop       = res.valid && res.ready;

    i2cms_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (take),
        .cmd               (cmd_in),
        .ticks_per_unit    (tpu_reg),
        .ack_timeout_limit (tmo_lim_reg),
        .res               (res_new)
    );

    // output buffer: slot0 is the head
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cnt_reg == 2'd2)
                slot0_reg <= slot1_reg;
            else
                slot0_reg <= res_new;
        end
        else if (take)
        begin
            if (cnt_reg == 2'd0)
                slot0_reg <= res_new;
            else
                slot1_reg <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (take && !pop)
            cnt_reg <= cnt_reg + 2'd1;
        else if (pop && !take)
            cnt_reg <= cnt_reg - 2'd1;
    end

    assign res.valid      = (cnt_reg != 2'd0);
    assign res.scl_level  = slot0_reg.scl_level;
    assign res.sda_level  = slot0_reg.sda_level;
    assign res.sda_drive  = slot0_reg.sda_drive;
    assign res.busy_res   = slot0_reg.busy_res;
    assign res.done_res   = slot0_reg.done_res;
    assign res.read_byte  = slot0_reg.read_byte;
    assign res.ack_failed = slot0_reg.ack_failed;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.done_res |-> !res.busy_res)
        else $error("completed transfer still reports busy");

    a_rbyte_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.read_byte != 8'd0 |-> res.done_res)
        else $error("read byte shown outside completion");

    a_fail_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ack_failed |-> res.done_res && res.scl_level && res.sda_level)
        else $error("ack failure without completed stop");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        take && !pop && cnt_reg == 2'd1 |=> cnt_reg == 2'd2 && !cmd.ready)
        else $error("output buffer fill tracking broken");
`endif

endmodule

@@ design/i2cms_core.sv @@
module i2cms_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  i2cms_pkg::cmd_t     cmd,
    input  logic [15:0]         ticks_per_unit,
    input  logic [15:0]         ack_timeout_limit,
    output i2cms_pkg::res_t     res
);

    i2cms_pkg::phase_t phase_reg, phase_next;
    logic [3:0]                  bits_reg, bits_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [i2cms_pkg::DELAY_W-1:0] delay_reg, delay_next;
    logic [15:0]                 tmo_reg, tmo_next;
    logic                        scl_reg, scl_next;
    logic                        sda_reg, sda_next;
    logic                        sda_en_reg, sda_en_next;
    logic                        ack_reg, ack_next;
    logic                        fail_reg, fail_next;

    logic [15:0]                 unit;
    logic [i2cms_pkg::DELAY_W-1:0] d1, d2, d4;
    logic                        expire;
    logic                        poll_ack;
    logic [15:0]                 tmo_src;
    logic [15:0]                 tmo_dec;
    logic                        tmo_out;
    logic [3:0]                  bits_dec;
    logic                        done;
    logic [7:0]                  rbyte;
    logic                        afail;

    assign unit     = (ticks_per_unit == 16'd0) ? 16'd1 : ticks_per_unit;
    assign d1       = {2'b00, unit};
    assign d2       = {1'b0, unit, 1'b0};
    assign d4       = {unit, 2'b00};
    assign expire   = (delay_reg <= {{(i2cms_pkg::DELAY_W-1){1'b0}}, 1'b1});
    assign poll_ack = !cmd.sda_sample;
    assign tmo_src  = (phase_reg == i2cms_pkg::PH_WA_POLL) ? tmo_reg :
                      ((ack_timeout_limit == 16'd0) ? 16'd1 : ack_timeout_limit);
    assign tmo_dec  = tmo_src - 16'd1;
    assign tmo_out  = (tmo_dec == 16'd0);
    assign bits_dec = bits_reg - 4'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == i2cms_pkg::PH_IDLE)
        begin
            unique case (cmd.kind)
                i2cms_pkg::KIND_START: phase_next = i2cms_pkg::PH_START_A;
                i2cms_pkg::KIND_STOP:  phase_next = i2cms_pkg::PH_STOP_A;
                i2cms_pkg::KIND_WRITE: phase_next = i2cms_pkg::PH_WR_SETUP;
                i2cms_pkg::KIND_READ:  phase_next = i2cms_pkg::PH_RD_LOW;
                i2cms_pkg::KIND_WAIT:  phase_next = i2cms_pkg::PH_WA_REL;
                default:               phase_next = i2cms_pkg::PH_IDLE;
            endcase
        end
        else if (phase_reg == i2cms_pkg::PH_WA_POLL || (phase_reg == i2cms_pkg::PH_WA_HIGH
                 && expire))
        begin
            priority if (poll_ack)
                phase_next = i2cms_pkg::PH_IDLE;
            else if (tmo_out)
                phase_next = i2cms_pkg::PH_STOP_A;
            else
                phase_next = i2cms_pkg::PH_WA_POLL;
        end
        else if (expire)
        begin
            unique case (phase_reg)
                i2cms_pkg::PH_START_A:  phase_next = i2cms_pkg::PH_START_B;
                i2cms_pkg::PH_STOP_A:   phase_next = i2cms_pkg::PH_STOP_B;
                i2cms_pkg::PH_WR_SETUP: phase_next = i2cms_pkg::PH_WR_HIGH;
                i2cms_pkg::PH_WR_HIGH:  phase_next = i2cms_pkg::PH_WR_LOW;
                i2cms_pkg::PH_WR_LOW:   phase_next = (bits_dec != 4'd0) ?
                                                     i2cms_pkg::PH_WR_SETUP :
                                                     i2cms_pkg::PH_IDLE;
                i2cms_pkg::PH_RD_LOW:   phase_next = i2cms_pkg::PH_RD_HIGH;
                i2cms_pkg::PH_RD_HIGH:  phase_next = i2cms_pkg::PH_RD_HOLD;
                i2cms_pkg::PH_RD_HOLD:  phase_next = (bits_dec != 4'd0) ?
                                                     i2cms_pkg::PH_RD_LOW :
                                                     i2cms_pkg::PH_AK_LOW;
                i2cms_pkg::PH_AK_LOW:   phase_next = i2cms_pkg::PH_AK_HIGH;
                i2cms_pkg::PH_WA_REL:   phase_next = i2cms_pkg::PH_WA_HIGH;
                default:                phase_next = i2cms_pkg::PH_IDLE;
            endcase
        end
    end

    // pins, counters and result flags
    always_comb
    begin
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        delay_next  = delay_reg;
        tmo_next    = tmo_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        sda_en_next = sda_en_reg;
        ack_next    = ack_reg;
        fail_next   = fail_reg;
        done        = 1'b0;
        rbyte       = 8'd0;
        afail       = 1'b0;
        if (phase_reg == i2cms_pkg::PH_IDLE)
        begin
            unique case (cmd.kind)
                i2cms_pkg::KIND_START:
                begin
                    sda_en_next = 1'b1;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                    delay_next  = d4;
                end
                i2cms_pkg::KIND_STOP:
                begin
                    fail_next   = 1'b0;
                    sda_en_next = 1'b1;
                    sda_next    = 1'b0;
                    scl_next    = 1'b0;
                    delay_next  = d4;
                end
                i2cms_pkg::KIND_WRITE:
                begin
                    sda_en_next = 1'b1;
                    scl_next    = 1'b0;
                    bits_next   = i2cms_pkg::BITS_PER_BYTE;
                    sda_next    = cmd.write_byte[7];
                    shift_next  = {cmd.write_byte[6:0], 1'b0};
                    delay_next  = d2;
                end
                i2cms_pkg::KIND_READ:
                begin
                    sda_en_next = 1'b0;
                    scl_next    = 1'b0;
                    shift_next  = 8'd0;
                    bits_next   = i2cms_pkg::BITS_PER_BYTE;
                    ack_next    = cmd.send_ack;
                    delay_next  = d2;
                end
                i2cms_pkg::KIND_WAIT:
                begin
                    sda_en_next = 1'b0;
                    sda_next    = 1'b1;
                    delay_next  = d1;
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == i2cms_pkg::PH_WA_POLL || (phase_reg == i2cms_pkg::PH_WA_HIGH
                 && expire))
        begin
            if (phase_reg == i2cms_pkg::PH_WA_HIGH)
                delay_next = '0;
            priority if (poll_ack)
            begin
                scl_next  = 1'b0;
                fail_next = 1'b0;
                done      = 1'b1;
            end
            else if (tmo_out)
            begin
                tmo_next    = tmo_dec;
                fail_next   = 1'b1;
                sda_en_next = 1'b1;
                sda_next    = 1'b0;
                scl_next    = 1'b0;
                delay_next  = d4;
            end
            else
                tmo_next = tmo_dec;
        end
        else if (!expire)
            delay_next = delay_reg - {{(i2cms_pkg::DELAY_W-1){1'b0}}, 1'b1};
        else
        begin
            delay_next = '0;
            unique case (phase_reg)
                i2cms_pkg::PH_START_A:
                begin
                    sda_next   = 1'b0;
                    delay_next = d4;
                end
                i2cms_pkg::PH_START_B:
                begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                i2cms_pkg::PH_STOP_A:
                begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    delay_next = d4;
                end
                i2cms_pkg::PH_STOP_B:
                begin
                    done  = 1'b1;
                    afail = fail_reg;
                end
                i2cms_pkg::PH_WR_SETUP:
                begin
                    scl_next   = 1'b1;
                    delay_next = d2;
                end
                i2cms_pkg::PH_WR_HIGH:
                begin
                    scl_next   = 1'b0;
                    delay_next = d2;
                end
                i2cms_pkg::PH_WR_LOW:
                begin
                    bits_next = bits_dec;
                    if (bits_dec != 4'd0)
                    begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        delay_next = d2;
                    end
                    else
                        done = 1'b1;
                end
                i2cms_pkg::PH_RD_LOW:
                begin
                    scl_next   = 1'b1;
                    delay_next = d2;
                end
                i2cms_pkg::PH_RD_HIGH:
                begin
                    shift_next = {shift_reg[6:0], cmd.sda_sample};
                    delay_next = d1;
                end
                i2cms_pkg::PH_RD_HOLD:
                begin
                    bits_next  = bits_dec;
                    scl_next   = 1'b0;
                    delay_next = d2;
                    if (bits_dec == 4'd0)
                    begin
                        sda_en_next = 1'b1;
                        sda_next    = !ack_reg;
                    end
                end
                i2cms_pkg::PH_AK_LOW:
                begin
                    scl_next   = 1'b1;
                    delay_next = d2;
                end
                i2cms_pkg::PH_AK_HIGH:
                begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                    rbyte    = shift_reg;
                end
                i2cms_pkg::PH_WA_REL:
                begin
                    scl_next   = 1'b1;
                    delay_next = d1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= i2cms_pkg::PH_IDLE;
            bits_reg   <= '0;
            shift_reg  <= '0;
            delay_reg  <= '0;
            tmo_reg    <= '0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            sda_en_reg <= 1'b1;
            ack_reg    <= 1'b0;
            fail_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bits_reg   <= bits_next;
            shift_reg  <= shift_next;
            delay_reg  <= delay_next;
            tmo_reg    <= tmo_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            sda_en_reg <= sda_en_next;
            ack_reg    <= ack_next;
            fail_reg   <= fail_next;
        end
    end

    assign res.scl_level  = scl_next;
    assign res.sda_level  = sda_next;
    assign res.sda_drive  = sda_en_next;
    assign res.busy_res   = (phase_next != i2cms_pkg::PH_IDLE);
    assign res.done_res   = done;
    assign res.read_byte  = rbyte;
    assign res.ack_failed = afail;

endmodule

@@ verif/tb_i2c_master_bit_sequencer.sv @@
module tb_i2c_master_bit_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned REPORT_MAX = 10;
    localparam int NEVER_ACK = 70000;
    localparam int RANDOM_SDA = -1;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [i2cms_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    i2cms_cmd_if cmd_ch ();
    i2cms_res_if res_ch ();

    i2c_master_bit_sequencer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch.sink),
        .res     (res_ch.source)
    );

    // sequencer prediction state
    i2cms_pkg::phase_t seq_phase;
    logic [3:0]        bits_left;
    logic [7:0]        shift_reg;
    int unsigned       delay_left;
    logic [15:0]       timeout_left;
    logic              scl_q;
    logic              sda_q;
    logic              sda_en_q;
    logic              ack_pick;
    logic              fail_q;
    logic [15:0]       unit_cfg;
    logic [15:0]       timeout_cfg;

    i2cms_pkg::res_t   expected_pins[$];

    int unsigned error_count;
    int unsigned ticks_sent;
    int unsigned results_checked;
    int unsigned reads_done;
    int unsigned waits_acked;
    int unsigned waits_timed_out;
    int unsigned cycle_count;
    int unsigned burst_left;
    bit          steady;

    logic [31:0] stall_mask;
    int unsigned stall_age;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d transfers outstanding",
                     cycle_count, expected_pins.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    function automatic int unsigned unit_ticks(input int unsigned n);
        int unsigned u;
        u = unit_cfg;
        if (u == 0)
            u = 1;
        return n * u;
    endfunction

    function automatic void reset_sequencer();
        seq_phase = i2cms_pkg::PH_IDLE;
        bits_left = '0;
        shift_reg = '0;
        delay_left = 0;
        timeout_left = '0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        sda_en_q = 1'b1;
        ack_pick = 1'b0;
        fail_q = 1'b0;
        unit_cfg = i2cms_pkg::TICKS_PER_UNIT_RST;
        timeout_cfg = i2cms_pkg::ACK_TIMEOUT_LIMIT_RST;
    endfunction

    function automatic void open_stop();
        sda_en_q = 1'b1;
        sda_q = 1'b0;
        scl_q = 1'b0;
        delay_left = unit_ticks(4);
        seq_phase = i2cms_pkg::PH_STOP_A;
    endfunction

    function automatic void shift_out();
        sda_q = shift_reg[7];
        shift_reg = shift_reg << 1;
    endfunction

    function automatic void poll_ack(input logic sda, inout logic done);
        if (!sda)
        begin
            scl_q = 1'b0;
            fail_q = 1'b0;
            seq_phase = i2cms_pkg::PH_IDLE;
            done = 1'b1;
            waits_acked++;
        end
        else
        begin
            timeout_left = timeout_left - 1'b1;
            if (timeout_left == 0)
            begin
                fail_q = 1'b1;
                open_stop();
            end
        end
    endfunction

    function automatic i2cms_pkg::res_t step_sequencer(input i2cms_pkg::cmd_t c);
        i2cms_pkg::res_t r;
        logic done;
        r = '0;
        done = 1'b0;
        if (seq_phase == i2cms_pkg::PH_IDLE)
        begin
            case (c.kind)
                i2cms_pkg::KIND_START:
                begin
                    sda_en_q = 1'b1;
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    delay_left = unit_ticks(4);
                    seq_phase = i2cms_pkg::PH_START_A;
                end
                i2cms_pkg::KIND_STOP:
                begin
                    fail_q = 1'b0;
                    open_stop();
                end
                i2cms_pkg::KIND_WRITE:
                begin
                    sda_en_q = 1'b1;
                    scl_q = 1'b0;
                    shift_reg = c.write_byte;
                    bits_left = i2cms_pkg::BITS_PER_BYTE;
                    shift_out();
                    delay_left = unit_ticks(2);
                    seq_phase = i2cms_pkg::PH_WR_SETUP;
                end
                i2cms_pkg::KIND_READ:
                begin
                    sda_en_q = 1'b0;
                    scl_q = 1'b0;
                    shift_reg = '0;
                    bits_left = i2cms_pkg::BITS_PER_BYTE;
                    ack_pick = c.send_ack;
                    delay_left = unit_ticks(2);
                    seq_phase = i2cms_pkg::PH_RD_LOW;
                end
                i2cms_pkg::KIND_WAIT:
                begin
                    sda_en_q = 1'b0;
                    sda_q = 1'b1;
                    delay_left = unit_ticks(1);
                    seq_phase = i2cms_pkg::PH_WA_REL;
                end
                default:
                begin
                end
            endcase
        end
        else if (seq_phase == i2cms_pkg::PH_WA_POLL)
            poll_ack(c.sda_sample, done);
        else if (delay_left > 1)
            delay_left--;
        else
        begin
            delay_left = 0;
            case (seq_phase)
                i2cms_pkg::PH_START_A:
                begin
                    sda_q = 1'b0;
                    delay_left = unit_ticks(4);
                    seq_phase = i2cms_pkg::PH_START_B;
                end
                i2cms_pkg::PH_START_B:
                begin
                    scl_q = 1'b0;
                    seq_phase = i2cms_pkg::PH_IDLE;
                    done = 1'b1;
                end
                i2cms_pkg::PH_STOP_A:
                begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    delay_left = unit_ticks(4);
                    seq_phase = i2cms_pkg::PH_STOP_B;
                end
                i2cms_pkg::PH_STOP_B:
                begin
                    seq_phase = i2cms_pkg::PH_IDLE;
                    done = 1'b1;
                    r.ack_failed = fail_q;
                    if (fail_q)
                        waits_timed_out++;
                end
                i2cms_pkg::PH_WR_SETUP:
                begin
                    scl_q = 1'b1;
                    delay_left = unit_ticks(2);
                    seq_phase = i2cms_pkg::PH_WR_HIGH;
                end
                i2cms_pkg::PH_WR_HIGH:
                begin
                    scl_q = 1'b0;
                    delay_left = unit_ticks(2);
                    seq_phase = i2cms_pkg::PH_WR_LOW;
                end
                i2cms_pkg::PH_WR_LOW:
                begin
                    bits_left = bits_left - 1'b1;
                    if (bits_left != 0)
                    begin
                        shift_out();
                        delay_left = unit_ticks(2);
                        seq_phase = i2cms_pkg::PH_WR_SETUP;
                    end
                    else
                    begin
                        seq_phase = i2cms_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                end
                i2cms_pkg::PH_RD_LOW:
                begin
                    scl_q = 1'b1;
                    delay_left = unit_ticks(2);
                    seq_phase = i2cms_pkg::PH_RD_HIGH;
                end
                i2cms_pkg::PH_RD_HIGH:
                begin
                    shift_reg = {shift_reg[6:0], c.sda_sample};
                    delay_left = unit_ticks(1);
                    seq_phase = i2cms_pkg::PH_RD_HOLD;
                end
                i2cms_pkg::PH_RD_HOLD:
                begin
                    bits_left = bits_left - 1'b1;
                    scl_q = 1'b0;
                    if (bits_left != 0)
                    begin
                        delay_left = unit_ticks(2);
                        seq_phase = i2cms_pkg::PH_RD_LOW;
                    end
                    else
                    begin
                        sda_en_q = 1'b1;
                        sda_q = !ack_pick;
                        delay_left = unit_ticks(2);
                        seq_phase = i2cms_pkg::PH_AK_LOW;
                    end
                end
                i2cms_pkg::PH_AK_LOW:
                begin
                    scl_q = 1'b1;
                    delay_left = unit_ticks(2);
                    seq_phase = i2cms_pkg::PH_AK_HIGH;
                end
                i2cms_pkg::PH_AK_HIGH:
                begin
                    scl_q = 1'b0;
                    seq_phase = i2cms_pkg::PH_IDLE;
                    done = 1'b1;
                    r.read_byte = shift_reg;
                    reads_done++;
                end
                i2cms_pkg::PH_WA_REL:
                begin
                    scl_q = 1'b1;
                    delay_left = unit_ticks(1);
                    seq_phase = i2cms_pkg::PH_WA_HIGH;
                end
                i2cms_pkg::PH_WA_HIGH:
                begin
                    timeout_left = (timeout_cfg == 0) ? 16'd1 : timeout_cfg;
                    seq_phase = i2cms_pkg::PH_WA_POLL;
                    poll_ack(c.sda_sample, done);
                end
                default:
                    seq_phase = i2cms_pkg::PH_IDLE;
            endcase
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive = sda_en_q;
        r.busy_res = (seq_phase != i2cms_pkg::PH_IDLE);
        r.done_res = done;
        return r;
    endfunction

    // receiver: always ready in steady mode, else stall on a rotating mask that is reloaded now and then
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (steady)
            res_ch.ready <= 1'b1;
        else
        begin
            if (stall_age == 0)
            begin
                stall_age = $urandom_range(32, 128);
                case ($urandom_range(0, 3))
                    0: stall_mask = '1;
                    1: stall_mask = $urandom | 32'h1;
                    default: stall_mask = $urandom | $urandom | 32'h1;
                endcase
            end
            stall_age--;
            res_ch.ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[31:1]};
        end
    end

    always @(posedge clk)
    begin : check_results
        i2cms_pkg::res_t seen;
        i2cms_pkg::res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.scl_level = res_ch.scl_level;
            seen.sda_level = res_ch.sda_level;
            seen.sda_drive = res_ch.sda_drive;
            seen.busy_res = res_ch.busy_res;
            seen.done_res = res_ch.done_res;
            seen.read_byte = res_ch.read_byte;
            seen.ack_failed = res_ch.ack_failed;
            if (expected_pins.size() == 0)
                log_error($sformatf("%0t: unexpected transfer scl=%b sda=%b drv=%b",
                                    $realtime, seen.scl_level, seen.sda_level,
                                    seen.sda_drive));
            else
            begin
                want = expected_pins.pop_front();
                results_checked++;
                if (seen.scl_level !== want.scl_level || seen.sda_level !== want.sda_level
                    || seen.sda_drive !== want.sda_drive || seen.busy_res !== want.busy_res
                    || seen.done_res !== want.done_res || seen.read_byte !== want.read_byte
                    || seen.ack_failed !== want.ack_failed)
                    log_error($sformatf({"%0t: result %0d mismatch, expected scl=%b sda=%b ",
                                         "drv=%b busy=%b done=%b rd=%h fail=%b, got scl=%b ",
                                         "sda=%b drv=%b busy=%b done=%b rd=%h fail=%b"},
                                        $realtime, results_checked,
                                        want.scl_level, want.sda_level, want.sda_drive,
                                        want.busy_res, want.done_res, want.read_byte,
                                        want.ack_failed,
                                        seen.scl_level, seen.sda_level, seen.sda_drive,
                                        seen.busy_res, seen.done_res, seen.read_byte,
                                        seen.ack_failed));
            end
        end
    end

    task automatic send_tick(input i2cms_pkg::cmd_t c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= c.kind;
        cmd_ch.write_byte <= c.write_byte;
        cmd_ch.send_ack <= c.send_ack;
        cmd_ch.sda_sample <= c.sda_sample;
        @(negedge clk);
        while (!cmd_ch.ready)
            @(negedge clk);
        @(posedge clk);
        expected_pins.push_back(step_sequencer(c));
        ticks_sent++;
    endtask

    // drive SDA high for the first high_polls acknowledge polls, then low; a negative high_polls leaves SDA random
    task automatic run_to_idle(input int high_polls, input bit noise);
        i2cms_pkg::cmd_t c;
        int   polls;
        bit   polling;
        polls = 0;
        while (seq_phase != i2cms_pkg::PH_IDLE)
        begin
            c.kind = noise ? 3'($urandom_range(0, 7)) : i2cms_pkg::KIND_TICK;
            c.write_byte = 8'($urandom);
            c.send_ack = 1'($urandom);
            c.sda_sample = 1'($urandom);
            polling = (seq_phase == i2cms_pkg::PH_WA_POLL) ||
                      (seq_phase == i2cms_pkg::PH_WA_HIGH && delay_left <= 1);
            if (polling && high_polls >= 0)
            begin
                c.sda_sample = (polls < high_polls);
                polls++;
            end
            send_tick(c);
        end
    endtask

    task automatic run_command(input logic [2:0] kind, input logic [7:0] data,
                               input logic ack, input int high_polls, input bit noise);
        i2cms_pkg::cmd_t c;
        c.kind = kind;
        c.write_byte = data;
        c.send_ack = ack;
        c.sda_sample = 1'($urandom);
        send_tick(c);
        run_to_idle(high_polls, noise);
    endtask

    task automatic wait_quiet();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pins.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [i2cms_pkg::ADDR_W-1:0] addr,
                             input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == i2cms_pkg::REG_TICKS_PER_UNIT)
            unit_cfg = value;
        else
            timeout_cfg = value;
    endtask

    task automatic check_reg(input logic [i2cms_pkg::ADDR_W-1:0] addr,
                             input logic [15:0] want);
        logic [31:0] got;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== {16'h0, want})
            log_error($sformatf("%0t: register at %0d reads %h, expected %h",
                                $realtime, addr, got, want));
    endtask

    task automatic configure(input logic [15:0] unit, input logic [15:0] limit);
        write_reg(i2cms_pkg::REG_TICKS_PER_UNIT, unit);
        write_reg(i2cms_pkg::REG_ACK_TIMEOUT_LIMIT, limit);
        check_reg(i2cms_pkg::REG_TICKS_PER_UNIT, unit);
        check_reg(i2cms_pkg::REG_ACK_TIMEOUT_LIMIT, limit);
    endtask

    task automatic test_register_defaults();
        check_reg(i2cms_pkg::REG_TICKS_PER_UNIT, i2cms_pkg::TICKS_PER_UNIT_RST);
        check_reg(i2cms_pkg::REG_ACK_TIMEOUT_LIMIT, i2cms_pkg::ACK_TIMEOUT_LIMIT_RST);
    endtask

    task automatic test_every_command();
        run_command(i2cms_pkg::KIND_TICK, 8'h00, 1'b0, RANDOM_SDA, 1'b0);
        run_command(KIND_SPARE_A, 8'hFF, 1'b1, RANDOM_SDA, 1'b0);
        run_command(KIND_SPARE_B, 8'h5A, 1'b1, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_START, 8'h00, 1'b0, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_WRITE, 8'h00, 1'b0, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 0, 1'b0);
        run_command(i2cms_pkg::KIND_WRITE, 8'hFF, 1'b1, RANDOM_SDA, 1'b1);
        run_command(i2cms_pkg::KIND_WAIT, 8'hFF, 1'b1, 3, 1'b1);
        run_command(i2cms_pkg::KIND_READ, 8'h00, 1'b1, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_READ, 8'hFF, 1'b0, RANDOM_SDA, 1'b1);
        run_command(i2cms_pkg::KIND_WRITE, 8'hA5, 1'b0, RANDOM_SDA, 1'b1);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 12, 1'b1);
        run_command(i2cms_pkg::KIND_STOP, 8'h00, 1'b0, RANDOM_SDA, 1'b1);
        wait_quiet();
    endtask

    task automatic test_zero_settings();
        configure(16'd0, 16'd0);
        run_command(i2cms_pkg::KIND_START, 8'h3C, 1'b0, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 1, 1'b0);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 0, 1'b1);
        run_command(i2cms_pkg::KIND_WRITE, 8'($urandom), 1'b0, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_READ, 8'h00, 1'b1, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_STOP, 8'h00, 1'b0, RANDOM_SDA, 1'b0);
        wait_quiet();
    endtask

    task automatic test_ack_timeout_edges();
        configure(16'd1, 16'd5);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 4, 1'b0);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 5, 1'b0);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 6, 1'b1);
        wait_quiet();
        configure(16'd1, 16'd40);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, NEVER_ACK, 1'b0);
        wait_quiet();
    endtask

    task automatic test_long_units();
        steady = 1'b1;
        configure(16'd5, 16'd3);
        run_command(i2cms_pkg::KIND_START, 8'h00, 1'b0, RANDOM_SDA, 1'b0);
        run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1'b0, 2, 1'b0);
        run_command(i2cms_pkg::KIND_STOP, 8'h00, 1'b0, RANDOM_SDA, 1'b1);
        wait_quiet();
        steady = 1'b0;
    endtask

    function automatic int ack_polls();
        int unsigned limit;
        limit = (timeout_cfg == 0) ? 1 : timeout_cfg;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, limit + 1);
        return $urandom_range(0, 1);
    endfunction

    task automatic random_frame();
        logic [7:0] addr;
        int         n;
        bit         noise;
        noise = ($urandom_range(0, 3) == 0);
        addr = 8'($urandom);
        n = $urandom_range(1, 3);
        run_command(i2cms_pkg::KIND_START, 8'($urandom), 1'($urandom), RANDOM_SDA, noise);
        run_command(i2cms_pkg::KIND_WRITE, addr, 1'($urandom), RANDOM_SDA, noise);
        run_command(i2cms_pkg::KIND_WAIT, 8'($urandom), 1'($urandom), ack_polls(), noise);
        for (int i = 0; i < n; i++)
        begin
            if (addr[0])
                run_command(i2cms_pkg::KIND_READ, 8'($urandom), (i != n - 1), RANDOM_SDA,
                            noise);
            else
            begin
                run_command(i2cms_pkg::KIND_WRITE, 8'($urandom), 1'($urandom), RANDOM_SDA,
                            noise);
                run_command(i2cms_pkg::KIND_WAIT, 8'($urandom), 1'($urandom), ack_polls(),
                            noise);
            end
        end
        run_command(i2cms_pkg::KIND_STOP, 8'($urandom), 1'($urandom), RANDOM_SDA, noise);
    endtask

    task automatic test_random_frames();
        logic [15:0] unit_pick[4];
        int unsigned round_end;
        unit_pick = '{16'd0, 16'd1, 16'd1, 16'd2};
        for (int round = 0; round < 2; round++)
        begin
            configure(unit_pick[$urandom_range(0, 3)], 16'($urandom_range(0, 8)));
            round_end = ticks_sent + 150;
            while (ticks_sent < round_end)
            begin
                if ($urandom_range(0, 3) != 0)
                    random_frame();
                else
                    run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                                $urandom_range(0, 1) ? RANDOM_SDA : ack_polls(),
                                1'($urandom));
            end
            wait_quiet();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = i2cms_pkg::KIND_TICK;
        cmd_ch.write_byte = '0;
        cmd_ch.send_ack = 1'b0;
        cmd_ch.sda_sample = 1'b1;
        res_ch.ready = 1'b0;
        steady = 1'b0;
        burst_left = 0;
        stall_age = 0;
        stall_mask = '1;
        error_count = 0;
        ticks_sent = 0;
        results_checked = 0;
        reads_done = 0;
        waits_acked = 0;
        waits_timed_out = 0;
        cycle_count = 0;
        reset_sequencer();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_every_command();
        test_zero_settings();
        test_ack_timeout_edges();
        test_long_units();
        test_random_frames();

        wait_quiet();
        repeat (4) @(posedge clk);
        if (expected_pins.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_pins.size()));
        $display("Covered %0d ticks and %0d checked transfers in %0d cycles",
                 ticks_sent, results_checked, cycle_count);
        $display("Completed %0d reads, %0d acknowledged waits, %0d timed-out waits",
                 reads_done, waits_acked, waits_timed_out);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
